FILE: sv/ale_pkg.sv
`timescale 1ns / 1ps

package ale_pkg;

   localparam int DEF_CAPACITY  = 128;
   localparam int DEF_ELEM_BITS = 32;

   // Packed word widths of the two channels, padded to whole bytes.
   localparam int REQ_W = 48;
   localparam int RSP_W = 56;

   // Operation codes carried in the func field.
   localparam logic [3:0] FUNC_CLEAR     = 4'd0;
   localparam logic [3:0] FUNC_GET       = 4'd1;
   localparam logic [3:0] FUNC_SET       = 4'd2;
   localparam logic [3:0] FUNC_SEARCH    = 4'd3;
   localparam logic [3:0] FUNC_INS_FIRST = 4'd4;
   localparam logic [3:0] FUNC_INS_AT    = 4'd5;
   localparam logic [3:0] FUNC_INS_LAST  = 4'd6;
   localparam logic [3:0] FUNC_DEL_FIRST = 4'd7;
   localparam logic [3:0] FUNC_DEL_AT    = 4'd8;
   localparam logic [3:0] FUNC_DEL_LAST  = 4'd9;

   // Status codes of a result word.
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;
   localparam logic [1:0] STAT_EMPTY     = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } ale_state_type;

   typedef enum logic [1:0] {
      OP_GET,
      OP_SEARCH,
      OP_INSERT,
      OP_DELETE
   } ale_op_type;

endpackage

FILE: sv/ale_ram.sv
`timescale 1ns / 1ps

module ale_ram #(
   parameter int DEPTH = ale_pkg::DEF_CAPACITY,
   parameter int WIDTH = ale_pkg::DEF_ELEM_BITS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/array_list_engine.sv
`timescale 1ns / 1ps

// Packed list engine. Each request word names one list operation (clear,
// get, set, search, insert at front/index/end, delete at front/index/end)
// and every request produces exactly one response word carrying the value
// read or removed, the search result, the element count after the
// operation and a status code.
// The elements live in a single-port-write memory with a registered read. Get,
// search, insert and delete stream through it one element per cycle: a
// read is issued each cycle, and for insert and delete each word read the
// cycle before, but the removed one, is written one place up or down. The
// elements read are 1 for get, count - index for inserts and deletes and
// count for a search that misses; a search that hits stops after the element
// that matched. Clear, set and rejected operations go from acceptance straight
// to forming the response, with no pass through the memory. One request is
// worked on at a time; the next can be taken in the cycle after the previous
// response is formed.
// Reset empties the list at once; memory contents are not cleared, since
// only entries below the count are ever read. A stalled response is held in
// the output register while the next request is accepted and processed; that
// request then waits in its final state until the output register is free.

module array_list_engine #(
   parameter int CAPACITY  = ale_pkg::DEF_CAPACITY,
   parameter int ELEM_BITS = ale_pkg::DEF_ELEM_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // func [3:0], position [10:4], value_in [42:11], zero padding above
   input  logic [ale_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // value_out [31:0], found_index [38:32], found [39], count_after [47:40],
   // status [49:48], zero padding above
   output logic [ale_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
   localparam int EV_W  = (ELEM_BITS > 32) ? ELEM_BITS : 32;
   localparam int FX_W  = (IDX_W > 7) ? IDX_W : 7;
   localparam int C8_W  = (CNT_W > 8) ? CNT_W : 8;

   // Request fields.
   logic [3:0]  req_func;
   logic [6:0]  req_position;
   logic [31:0] req_value_in;

   assign req_func     = req_tdata[3:0];
   assign req_position = req_tdata[10:4];
   assign req_value_in = req_tdata[42:11];

   // Control and working registers.
   ale_pkg::ale_state_type state_ff, state_in;
   ale_pkg::ale_op_type    op_ff, op_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       at_ff, at_in;
   logic [ELEM_BITS-1:0]   val_ff, val_in;
   logic [IDX_W-1:0]       addr_ff, addr_in;
   logic [CNT_W-1:0]       left_ff, left_in;
   logic                   dv_ff, dv_in;
   logic [IDX_W-1:0]       daddr_ff, daddr_in;
   logic [ELEM_BITS-1:0]   vout_ff, vout_in;
   logic [IDX_W-1:0]       fidx_ff, fidx_in;
   logic                   found_ff, found_in;
   logic [1:0]             status_ff, status_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [ale_pkg::RSP_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // Decode of the incoming request against the current count.
   logic                   dec_run;
   logic                   dec_set;
   ale_pkg::ale_op_type    dec_op;
   logic [1:0]             dec_status;
   logic [CNT_W-1:0]       dec_count;
   logic [CNT_W-1:0]       dec_left;
   logic [IDX_W-1:0]       dec_addr;
   logic [IDX_W-1:0]       dec_at;
   logic [CMP_W-1:0]       pos_c;
   logic [CMP_W-1:0]       cnt_c;
   logic [CMP_W-1:0]       at_c;
   logic [CNT_W-1:0]       cnt_m1;
   logic                   list_empty;
   logic                   list_full;
   logic [EV_W-1:0]        val_wide;
   logic [ELEM_BITS-1:0]   val_elem;

   // Memory port and sequencer strobes.
   logic                   accept;
   logic                   run_active;
   logic                   rd_en;
   logic [ELEM_BITS-1:0]   rd_data;
   logic                   match;
   logic                   run_end;
   logic                   rsp_load;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [ELEM_BITS-1:0]   wr_data;

   // Response field formatting.
   logic [EV_W-1:0]        vout_wide;
   logic [FX_W-1:0]        fidx_wide;
   logic [C8_W-1:0]        count_wide;

   assign pos_c      = CMP_W'(req_position);
   assign cnt_c      = CMP_W'(count_ff);
   assign cnt_m1     = count_ff - CNT_W'(1);
   assign list_empty = (count_ff == '0);
   assign list_full  = (count_ff == CNT_W'(CAPACITY));
   assign val_wide   = EV_W'(req_value_in);
   assign val_elem   = val_wide[ELEM_BITS-1:0];

   always_comb begin
      dec_run    = 1'b0;
      dec_set    = 1'b0;
      dec_op     = ale_pkg::OP_GET;
      dec_status = ale_pkg::STAT_OK;
      dec_count  = count_ff;
      dec_left   = '0;
      dec_addr   = '0;
      dec_at     = '0;
      at_c       = '0;
      unique case (req_func) inside
         ale_pkg::FUNC_CLEAR: begin
            dec_count = '0;
         end
         ale_pkg::FUNC_GET, ale_pkg::FUNC_SET: begin
            if (list_empty) begin
               dec_status = ale_pkg::STAT_EMPTY;
            end else if (pos_c >= cnt_c) begin
               dec_status = ale_pkg::STAT_BAD_INDEX;
            end else if (req_func == ale_pkg::FUNC_GET) begin
               dec_run  = 1'b1;
               dec_op   = ale_pkg::OP_GET;
               dec_left = CNT_W'(1);
               dec_addr = pos_c[IDX_W-1:0];
            end else begin
               dec_set = 1'b1;
            end
         end
         ale_pkg::FUNC_SEARCH: begin
            dec_run  = 1'b1;
            dec_op   = ale_pkg::OP_SEARCH;
            dec_left = count_ff;
         end
         ale_pkg::FUNC_INS_FIRST, ale_pkg::FUNC_INS_AT, ale_pkg::FUNC_INS_LAST: begin
            if (list_full) begin
               dec_status = ale_pkg::STAT_FULL;
            end else begin
               if (req_func == ale_pkg::FUNC_INS_FIRST) begin
                  at_c = '0;
               end else if (req_func == ale_pkg::FUNC_INS_LAST) begin
                  at_c = cnt_c;
               end else begin
                  at_c = pos_c;
               end
               if (at_c > cnt_c) begin
                  dec_status = ale_pkg::STAT_BAD_INDEX;
               end else begin
                  dec_run   = 1'b1;
                  dec_op    = ale_pkg::OP_INSERT;
                  dec_left  = CNT_W'(cnt_c - at_c);
                  dec_addr  = cnt_m1[IDX_W-1:0];
                  dec_at    = at_c[IDX_W-1:0];
                  dec_count = count_ff + CNT_W'(1);
               end
            end
         end
         ale_pkg::FUNC_DEL_FIRST, ale_pkg::FUNC_DEL_AT, ale_pkg::FUNC_DEL_LAST: begin
            if (list_empty) begin
               dec_status = ale_pkg::STAT_EMPTY;
            end else begin
               if (req_func == ale_pkg::FUNC_DEL_FIRST) begin
                  at_c = '0;
               end else if (req_func == ale_pkg::FUNC_DEL_LAST) begin
                  at_c = CMP_W'(cnt_m1);
               end else begin
                  at_c = pos_c;
               end
               if (at_c >= cnt_c) begin
                  dec_status = ale_pkg::STAT_BAD_INDEX;
               end else begin
                  dec_run   = 1'b1;
                  dec_op    = ale_pkg::OP_DELETE;
                  dec_left  = CNT_W'(cnt_c - at_c);
                  dec_addr  = at_c[IDX_W-1:0];
                  dec_at    = at_c[IDX_W-1:0];
                  dec_count = cnt_m1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ale_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = dec_run ? ale_pkg::ST_RUN : ale_pkg::ST_DONE;
            end
         end
         ale_pkg::ST_RUN: begin
            if (run_end) begin
               state_in = ale_pkg::ST_DONE;
            end
         end
         ale_pkg::ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = ale_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ale_pkg::ST_IDLE;
         end
      endcase
   end

   // State-machine outputs.
   always_comb begin
      req_tready = (state_ff == ale_pkg::ST_IDLE);
      run_active = (state_ff == ale_pkg::ST_RUN);
      rsp_load   = (state_ff == ale_pkg::ST_DONE) && (!rsp_tvalid_ff || rsp_tready);
      accept     = req_tready && req_tvalid;
      rd_en      = run_active && (left_ff != '0);
      match      = run_active && dv_ff && (op_ff == ale_pkg::OP_SEARCH) && (rd_data == val_ff);
      run_end    = run_active && (((left_ff == '0) && !dv_ff) || match);
   end

   // Memory write port. The word read in the previous cycle is written one
   // place up for an insert and one place down for a delete; the removed
   // word of a delete is captured rather than written.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = daddr_ff;
      wr_data = rd_data;
      if (accept && dec_set) begin
         wr_en   = 1'b1;
         wr_addr = pos_c[IDX_W-1:0];
         wr_data = val_elem;
      end else if (run_active && dv_ff && (op_ff == ale_pkg::OP_INSERT)) begin
         wr_en   = 1'b1;
         wr_addr = daddr_ff + IDX_W'(1);
      end else if (run_active && dv_ff && (op_ff == ale_pkg::OP_DELETE) && (daddr_ff != at_ff)) begin
         wr_en   = 1'b1;
         wr_addr = daddr_ff - IDX_W'(1);
      end else if (run_end && (op_ff == ale_pkg::OP_INSERT)) begin
         wr_en   = 1'b1;
         wr_addr = at_ff;
         wr_data = val_ff;
      end
   end

   // Datapath next values.
   always_comb begin
      op_in     = op_ff;
      count_in  = count_ff;
      at_in     = at_ff;
      val_in    = val_ff;
      addr_in   = addr_ff;
      left_in   = left_ff;
      daddr_in  = addr_ff;
      dv_in     = 1'b0;
      vout_in   = vout_ff;
      fidx_in   = fidx_ff;
      found_in  = found_ff;
      status_in = status_ff;
      if (accept) begin
         op_in     = dec_op;
         count_in  = dec_count;
         at_in     = dec_at;
         val_in    = val_elem;
         addr_in   = dec_addr;
         left_in   = dec_left;
         vout_in   = '0;
         fidx_in   = '0;
         found_in  = 1'b0;
         status_in = dec_status;
      end
      if (rd_en) begin
         left_in = left_ff - CNT_W'(1);
         if (op_ff == ale_pkg::OP_INSERT) begin
            addr_in = addr_ff - IDX_W'(1);
         end else begin
            addr_in = addr_ff + IDX_W'(1);
         end
         // A read still in flight when a search hits is dropped.
         dv_in = !run_end;
      end
      if (run_active && dv_ff) begin
         if ((op_ff == ale_pkg::OP_GET) ||
             ((op_ff == ale_pkg::OP_DELETE) && (daddr_ff == at_ff))) begin
            vout_in = rd_data;
         end
         if (match) begin
            found_in = 1'b1;
            fidx_in  = daddr_ff;
         end
      end
   end

   assign vout_wide  = EV_W'(vout_ff);
   assign fidx_wide  = FX_W'(fidx_ff);
   assign count_wide = C8_W'(count_ff);

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {6'd0, status_ff, count_wide[7:0], found_ff,
                          fidx_wide[6:0], vout_wide[31:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ale_pkg::ST_IDLE;
         count_ff      <= '0;
         dv_ff         <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         dv_ff         <= dv_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      at_ff        <= at_in;
      val_ff       <= val_in;
      addr_ff      <= addr_in;
      left_ff      <= left_in;
      daddr_ff     <= daddr_in;
      vout_ff      <= vout_in;
      fidx_ff      <= fidx_in;
      found_ff     <= found_in;
      status_ff    <= status_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   ale_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (ELEM_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count exceeds capacity");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (wr_addr != addr_ff))
      else $error("shift writes the entry it is reading");

   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ale_pkg::ST_DONE) |-> !dv_ff)
      else $error("memory read still pending when the response is formed");

   a_run_leaves_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (run_active && (left_ff != '0) && !match) |=> (state_ff == ale_pkg::ST_RUN))
      else $error("sequencer left the run with reads outstanding");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tdata_ff[39]) |-> (rsp_tdata_ff[49:48] == ale_pkg::STAT_OK))
      else $error("search hit reported with an error status");

endmodule
